/* rtl/tscd_pkg.sv */
// ----------------------------------------------------------------------------
// tscd_pkg: shared definitions for the two-sided CUSUM detector
// Widths, register indexes, saturation limits and the sum-step result type.
// ----------------------------------------------------------------------------
`default_nettype none

package tscd_pkg;

    // Width of the incoming prediction sample (legal range 16 to 48).
    localparam int SAMPLE_W  = 32;

    // Register and payload widths fixed by the Q16.16 format.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 8;

    // Difference (sample - mean) needs one bit more than the wider operand.
    localparam int EXT_W     = (SAMPLE_W > 32) ? SAMPLE_W : 32;
    localparam int DIFF_W    = EXT_W + 1;
    // Magnitude is split into a low 32-bit word and a high part.
    localparam int HI_W      = DIFF_W - 32;
    localparam int PLO_W     = 64;
    localparam int PHI_W     = HI_W + 32;
    // Recombined quotient: 48 bits of the low product plus a carry bit.
    localparam int Q_W       = 49;
    // Accumulator update headroom: 32-bit sum plus and minus 32-bit terms.
    localparam int SUM_W     = 35;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_OFFSET      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_VARIANCE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_ALLOWANCE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_THRESHOLD  = CFG_IDX_W'(3);

    // Register reset values.
    localparam logic [CFG_W-1:0] RST_MEAN_OFFSET      = 32'd0;
    localparam logic [CFG_W-1:0] RST_INVERSE_VARIANCE = 32'd65536;
    localparam logic [CFG_W-1:0] RST_DRIFT_ALLOWANCE  = 32'd0;
    localparam logic [CFG_W-1:0] RST_ALARM_THRESHOLD  = 32'd327680;

    // Saturation limits of the normalized value.
    localparam logic [31:0]    Z_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0]    Z_NEG_MIN = 32'h8000_0000;
    localparam logic [Q_W-1:0] Q_POS_LIM = Q_W'(32'h7FFF_FFFF);
    localparam logic [Q_W-1:0] Q_NEG_LIM = Q_W'(32'h8000_0000);

    // Saturation limit of a cumulative sum.
    localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;

    // Outcome of one clamped cumulative-sum step.
    typedef struct packed {
        logic [31:0] sum;
        logic        alarm;
    } t_sum_step;

endpackage

`default_nettype wire

/* rtl/tscd_sum_step.sv */
// ----------------------------------------------------------------------------
// tscd_sum_step: one clamped cumulative-sum update with alarm compare
// Computes acc + term - drift, clamps it to [0, 2^32-1] and flags it when it
// lies strictly above the threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module tscd_sum_step (
    input  wire logic [31:0]                       i_acc,
    input  wire logic signed [tscd_pkg::SUM_W-1:0] i_term,
    input  wire logic [31:0]                       i_drift,
    input  wire logic [31:0]                       i_threshold,
    output tscd_pkg::t_sum_step                    o_result
);

    logic signed [tscd_pkg::SUM_W-1:0] raw;
    logic [31:0]                       clamped;

    always_comb begin
        raw = $signed({3'b000, i_acc}) + i_term - $signed({3'b000, i_drift});
        if (raw[tscd_pkg::SUM_W-1]) begin
            clamped = 32'd0;
        end else if (raw[tscd_pkg::SUM_W-2:32] != '0) begin
            clamped = tscd_pkg::SUM_MAX;
        end else begin
            clamped = raw[31:0];
        end
        o_result.sum   = clamped;
        o_result.alarm = (clamped > i_threshold);
    end

endmodule

`default_nettype wire

/* rtl/two_sided_cusum_detector.sv */
// ----------------------------------------------------------------------------
// two_sided_cusum_detector: normalizing two-sided CUSUM change detector
// Normalizes each Q16.16 sample and updates clamped upper and lower sums.
// ----------------------------------------------------------------------------
// The block takes one signed Q16.16 sample per transaction and returns one
// result per transaction: the normalized value z = (sample - mean_offset) *
// inverse_variance, truncated toward zero and saturated to 32 bits, the upper
// sum (sum + z - drift) and lower sum (sum - z - drift), each clamped to
// [0, 2^32-1], and an alarm bit for each sum that lies strictly above
// alarm_threshold. A five-stage pipeline (input register, subtract and
// magnitude, split multiply, recombine and saturate, sum update) accepts one
// sample every cycle while o_stall is low; each result passes through the
// stage A to D registers into the output register. The sustained rate of
// one item per cycle is set by the sum-update stage, whose accumulators
// feed back into themselves on every update. Stages hold their contents
// independently, so a new sample is still accepted while a result waits,
// as long as an empty stage remains somewhere in the pipeline.
// Configuration writes take effect at the next clock edge and are meant to be
// made while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module two_sided_cusum_detector (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    // Configuration write port.
    input  wire logic                              i_cfg_we,
    input  wire logic [tscd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tscd_pkg::CFG_W-1:0]        i_cfg_data,

    // Sample channel.
    input  wire logic                              i_valid,
    output      logic                              o_stall,
    input  wire logic signed [tscd_pkg::SAMPLE_W-1:0] i_sample,

    // Result channel.
    output      logic                              o_valid,
    input  wire logic                              i_stall,
    output      logic signed [31:0]                o_normalized,
    output      logic [31:0]                       o_upper_sum,
    output      logic [31:0]                       o_lower_sum,
    output      logic                              o_upper_alarm,
    output      logic                              o_lower_alarm
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_mean_offset;
    logic [31:0] r_inverse_variance;
    logic [31:0] r_drift_allowance;
    logic [31:0] r_alarm_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_offset      <= tscd_pkg::RST_MEAN_OFFSET;
            r_inverse_variance <= tscd_pkg::RST_INVERSE_VARIANCE;
            r_drift_allowance  <= tscd_pkg::RST_DRIFT_ALLOWANCE;
            r_alarm_threshold  <= tscd_pkg::RST_ALARM_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tscd_pkg::CFG_MEAN_OFFSET:      r_mean_offset      <= i_cfg_data;
                tscd_pkg::CFG_INVERSE_VARIANCE: r_inverse_variance <= i_cfg_data;
                tscd_pkg::CFG_DRIFT_ALLOWANCE:  r_drift_allowance  <= i_cfg_data;
                tscd_pkg::CFG_ALARM_THRESHOLD:  r_alarm_threshold  <= i_cfg_data;
                default: begin
                    // Writes to unmapped indexes are dropped.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    // Each stage loads when it is empty or when the stage after it loads.
    // Stage A is the input register, E is the output register.
    logic r_a_valid;
    logic r_b_valid;
    logic r_c_valid;
    logic r_d_valid;
    logic r_e_valid;

    logic e_ready;
    logic d_ready;
    logic c_ready;
    logic b_ready;
    logic a_ready;

    always_comb begin
        e_ready = !r_e_valid || !i_stall;
        d_ready = !r_d_valid || e_ready;
        c_ready = !r_c_valid || d_ready;
        b_ready = !r_b_valid || c_ready;
        a_ready = !r_a_valid || b_ready;
    end

    assign o_stall = !a_ready;
    assign o_valid = r_e_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
            if (d_ready) begin
                r_d_valid <= r_c_valid;
            end
            if (e_ready) begin
                r_e_valid <= r_d_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    logic [tscd_pkg::SAMPLE_W-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_sample <= i_sample;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: difference from the mean, split into sign and magnitude
    // ------------------------------------------------------------------
    logic [tscd_pkg::DIFF_W-1:0] n_diff;
    logic [tscd_pkg::DIFF_W-1:0] n_mag;
    logic                        r_b_neg;
    logic [tscd_pkg::DIFF_W-1:0] r_b_mag;

    always_comb begin
        n_diff = {{(tscd_pkg::DIFF_W - tscd_pkg::SAMPLE_W){r_sample[tscd_pkg::SAMPLE_W-1]}},
                  r_sample}
               - {{(tscd_pkg::DIFF_W - 32){r_mean_offset[31]}}, r_mean_offset};
        // The difference never reaches the most negative code, so negation is safe.
        n_mag  = n_diff[tscd_pkg::DIFF_W-1] ? (~n_diff + tscd_pkg::DIFF_W'(1)) : n_diff;
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_neg <= n_diff[tscd_pkg::DIFF_W-1];
            r_b_mag <= n_mag;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: magnitude times gain as two partial products
    // ------------------------------------------------------------------
    logic                         r_c_neg;
    logic [tscd_pkg::PLO_W-1:0]   r_c_plo;
    logic [tscd_pkg::PHI_W-1:0]   r_c_phi;

    always_ff @(posedge i_clk) begin
        if (c_ready && r_b_valid) begin
            r_c_neg <= r_b_neg;
            r_c_plo <= tscd_pkg::PLO_W'(r_b_mag[31:0]) * tscd_pkg::PLO_W'(r_inverse_variance);
            r_c_phi <= tscd_pkg::PHI_W'(r_b_mag[tscd_pkg::DIFF_W-1:32])
                     * tscd_pkg::PHI_W'(r_inverse_variance);
        end
    end

    // ------------------------------------------------------------------
    // Stage D: recombine, drop 16 fraction bits, saturate to 32 bits
    // ------------------------------------------------------------------
    logic                     n_big;
    logic [tscd_pkg::Q_W-1:0] n_q;
    logic [31:0]              n_z;
    logic signed [31:0]       r_d_z;

    always_comb begin
        // A high partial product at or above 2^16 puts the result far out of range.
        n_big = (r_c_phi[tscd_pkg::PHI_W-1:16] != '0);
        n_q   = {1'b0, r_c_plo[63:16]} + {17'b0, r_c_phi[15:0], 16'b0};
        if (r_c_neg) begin
            if (n_big || (n_q > tscd_pkg::Q_NEG_LIM)) begin
                n_z = tscd_pkg::Z_NEG_MIN;
            end else begin
                n_z = ~n_q[31:0] + 32'd1;
            end
        end else begin
            if (n_big || (n_q > tscd_pkg::Q_POS_LIM)) begin
                n_z = tscd_pkg::Z_POS_MAX;
            end else begin
                n_z = n_q[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_ready && r_c_valid) begin
            r_d_z <= n_z;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: cumulative sums, alarms and output register
    // ------------------------------------------------------------------
    // The accumulators double as the sum fields of the output register.
    logic signed [tscd_pkg::SUM_W-1:0] upper_term;
    logic signed [tscd_pkg::SUM_W-1:0] lower_term;
    tscd_pkg::t_sum_step               upper_step;
    tscd_pkg::t_sum_step               lower_step;

    logic [31:0]        r_upper_acc;
    logic [31:0]        r_lower_acc;
    logic signed [31:0] r_normalized;
    logic               r_upper_alarm;
    logic               r_lower_alarm;

    assign upper_term = {{(tscd_pkg::SUM_W - 32){r_d_z[31]}}, r_d_z};
    assign lower_term = -upper_term;

    tscd_sum_step u_upper_step (
        .i_acc       (r_upper_acc),
        .i_term      (upper_term),
        .i_drift     (r_drift_allowance),
        .i_threshold (r_alarm_threshold),
        .o_result    (upper_step)
    );

    tscd_sum_step u_lower_step (
        .i_acc       (r_lower_acc),
        .i_term      (lower_term),
        .i_drift     (r_drift_allowance),
        .i_threshold (r_alarm_threshold),
        .o_result    (lower_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_acc <= 32'd0;
            r_lower_acc <= 32'd0;
        end else if (e_ready && r_d_valid) begin
            r_upper_acc <= upper_step.sum;
            r_lower_acc <= lower_step.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_ready && r_d_valid) begin
            r_normalized  <= r_d_z;
            r_upper_alarm <= upper_step.alarm;
            r_lower_alarm <= lower_step.alarm;
        end
    end

    assign o_normalized  = r_normalized;
    assign o_upper_sum   = r_upper_acc;
    assign o_lower_sum   = r_lower_acc;
    assign o_upper_alarm = r_upper_alarm;
    assign o_lower_alarm = r_lower_alarm;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input back-pressure only appears when every stage holds a transaction.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_valid && r_b_valid && r_c_valid && r_d_valid && r_e_valid))
        else $error("input stalled while a pipeline stage was empty");

    // The accumulators move only when a transaction enters the output stage.
    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(e_ready && r_d_valid) |=> ($stable(r_upper_acc) && $stable(r_lower_acc)))
        else $error("accumulator changed without a sum update");

    // A delivered result with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && !i_stall && !r_d_valid) |=> !r_e_valid)
        else $error("output stayed valid after its transaction was taken");

    // A pending result's alarms agree with its sums and the current threshold.
    a_alarm_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> ((r_upper_alarm == (r_upper_acc > r_alarm_threshold))
                    && (r_lower_alarm == (r_lower_acc > r_alarm_threshold))))
        else $error("alarm flag disagrees with its sum");

endmodule

`default_nettype wire

/* sim/two_sided_cusum_detector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_sided_cusum_detector_tb: self-checking bench for the CUSUM detector
// Drives sample transactions through the valid/stall channel, predicts every
// result with a behavioral model of the normalizer and the two clamped sums,
// and compares each delivered result field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module two_sided_cusum_detector_tb;

    // Clock and run control.
    localparam int CLK_HALF      = 5;
    localparam int PIPE_LATENCY  = 4;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 5;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MAX_REPORTS   = 40;

    // Saturation bounds of the normalized value, held as 64-bit signed numbers.
    localparam longint Z_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Z_MIN = -64'sh0000_0000_8000_0000;

    // Register indexes that do not name a register; writes to them must be dropped.
    localparam logic [tscd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_FIRST = tscd_pkg::CFG_IDX_W'(4);
    localparam logic [tscd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_MID   = tscd_pkg::CFG_IDX_W'(8'h80);
    localparam logic [tscd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_TOP   = '1;

    // One expected result transaction.
    typedef struct packed {
        logic signed [31:0] normalized;
        logic [31:0]        upper_sum;
        logic [31:0]        lower_sum;
        logic               upper_alarm;
        logic               lower_alarm;
    } t_cusum_result;

    // Every input carries a known value from time zero.
    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_cfg_we    = 1'b0;
    logic [tscd_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [tscd_pkg::CFG_W-1:0]           i_cfg_data  = '0;
    logic                                 i_valid     = 1'b0;
    logic signed [tscd_pkg::SAMPLE_W-1:0] i_sample    = '0;
    logic                                 i_stall     = 1'b0;
    logic                                 o_stall;
    logic                                 o_valid;
    logic signed [31:0]                   o_normalized;
    logic [31:0]                          o_upper_sum;
    logic [31:0]                          o_lower_sum;
    logic                                 o_upper_alarm;
    logic                                 o_lower_alarm;

    // Shadow copy of the configuration and the two accumulators.
    logic signed [31:0] model_mean      = tscd_pkg::RST_MEAN_OFFSET;
    logic [31:0]        model_gain      = tscd_pkg::RST_INVERSE_VARIANCE;
    logic [31:0]        model_drift     = tscd_pkg::RST_DRIFT_ALLOWANCE;
    logic [31:0]        model_threshold = tscd_pkg::RST_ALARM_THRESHOLD;
    logic [31:0]        model_upper     = '0;
    logic [31:0]        model_lower     = '0;

    // Results predicted for accepted samples and not yet delivered, oldest first.
    t_cusum_result pending_results[$];
    t_cusum_result head_result;

    // Idle rates in percent of cycles for the sample side and the result side.
    int send_idle_pct  = 25;
    int recv_stall_pct = 85;

    int mismatch_count = 0;
    int result_count   = 0;
    int cycle_count    = 0;

    two_sided_cusum_detector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_normalized  (o_normalized),
        .o_upper_sum   (o_upper_sum),
        .o_lower_sum   (o_lower_sum),
        .o_upper_alarm (o_upper_alarm),
        .o_lower_alarm (o_lower_alarm)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // A hung pipeline or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // The result side stalls at random; the rate changes between test phases.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Prints one line per mismatch, up to a cap, and counts all of them.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    // Mirrors a register write into the shadow configuration. Indexes past the
    // last register are dropped, as the hardware drops them.
    function automatic void shadow_reg_write(input logic [tscd_pkg::CFG_IDX_W-1:0] idx,
                                             input logic [tscd_pkg::CFG_W-1:0] data);
        case (idx)
            tscd_pkg::CFG_MEAN_OFFSET:      model_mean      = data;
            tscd_pkg::CFG_INVERSE_VARIANCE: model_gain      = data;
            tscd_pkg::CFG_DRIFT_ALLOWANCE:  model_drift     = data;
            tscd_pkg::CFG_ALARM_THRESHOLD:  model_threshold = data;
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] clamp_sum(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > longint'(tscd_pkg::SUM_MAX)) begin
            return tscd_pkg::SUM_MAX;
        end
        return v[31:0];
    endfunction

    // Predicts the result of one sample and advances both accumulators.
    // The product of the difference and the gain carries 32 fraction bits; it
    // is cut to 16 by truncation toward zero, so the magnitude is scaled and
    // the sign put back afterwards. The 96-bit product covers the widest
    // sample the block can be built with.
    function automatic t_cusum_result predict_cusum(
        input logic signed [tscd_pkg::SAMPLE_W-1:0] smp);
        longint        diff;
        longint        z;
        logic [95:0]   mag;
        logic [95:0]   quot;
        t_cusum_result r;
        diff = longint'(smp) - longint'(model_mean);
        mag  = (diff < 0) ? 96'(-diff) : 96'(diff);
        quot = (mag * 96'(model_gain)) >> 16;
        if (diff < 0) begin
            z = (quot > 96'h8000_0000) ? Z_MIN : -longint'(quot[40:0]);
        end else begin
            z = (quot > 96'h7FFF_FFFF) ? Z_MAX : longint'(quot[40:0]);
        end
        // The sums use the saturated z and clamp to the unsigned 32-bit range.
        model_upper = clamp_sum(longint'(model_upper) + z - longint'(model_drift));
        model_lower = clamp_sum(longint'(model_lower) - z - longint'(model_drift));
        r.normalized  = z[31:0];
        r.upper_sum   = model_upper;
        r.lower_sum   = model_lower;
        r.upper_alarm = (model_upper > model_threshold);
        r.lower_alarm = (model_lower > model_threshold);
        return r;
    endfunction

    // Sends one sample transaction. Entered and left in the time step of a
    // rising edge, so valid is assigned at most once per step and stays high
    // across back-to-back transactions.
    task automatic send_sample(input logic signed [tscd_pkg::SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pending_results.push_back(predict_cusum(smp));
    endtask

    // Stops sending and waits until every predicted result has come out, then
    // lets the pipeline settle so that a register write finds it empty.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the enable drops in the following cycle so that it
    // is never lowered and raised within one time step.
    task automatic write_reg(input logic [tscd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tscd_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        shadow_reg_write(idx, data);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] mean, input logic [31:0] gain,
                              input logic [31:0] drift, input logic [31:0] threshold);
        wait_idle();
        write_reg(tscd_pkg::CFG_MEAN_OFFSET, mean);
        write_reg(tscd_pkg::CFG_INVERSE_VARIANCE, gain);
        write_reg(tscd_pkg::CFG_DRIFT_ALLOWANCE, drift);
        write_reg(tscd_pkg::CFG_ALARM_THRESHOLD, threshold);
    endtask

    // Result checker: every delivered transaction is matched against the
    // oldest prediction. A failure is counted and the run continues.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            result_count <= result_count + 1;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no sample pending",
                                          result_count));
            end else begin
                head_result = pending_results.pop_front();
                if (o_normalized !== head_result.normalized)
                    report_mismatch($sformatf("result %0d normalized %h, want %h",
                                    result_count, o_normalized, head_result.normalized));
                if (o_upper_sum !== head_result.upper_sum)
                    report_mismatch($sformatf("result %0d upper_sum %h, want %h",
                                    result_count, o_upper_sum, head_result.upper_sum));
                if (o_lower_sum !== head_result.lower_sum)
                    report_mismatch($sformatf("result %0d lower_sum %h, want %h",
                                    result_count, o_lower_sum, head_result.lower_sum));
                if (o_upper_alarm !== head_result.upper_alarm)
                    report_mismatch($sformatf("result %0d upper_alarm %b, want %b",
                                    result_count, o_upper_alarm, head_result.upper_alarm));
                if (o_lower_alarm !== head_result.lower_alarm)
                    report_mismatch($sformatf("result %0d lower_alarm %b, want %b",
                                    result_count, o_lower_alarm, head_result.lower_alarm));
            end
        end
    end

    // With the reset configuration (gain 1.0, threshold 5.0) a sample of
    // exactly 5.0 sits on the threshold and must not raise the alarm; one
    // more LSB must. The extreme sample codes follow.
    task automatic test_reset_defaults();
        send_sample(32'sh0000_0000);
        send_sample(32'sh0005_0000);
        send_sample(32'sh0000_0001);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'shFFFF_FFFF);
    endtask

    // Largest difference times largest gain: z saturates at both ends and the
    // sums pin at all ones. A threshold of all ones never alarms, one of zero
    // alarms on any nonzero sum.
    task automatic test_saturation();
        set_config(32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh7FFF_FFFF);
        set_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_sample(32'sh8000_0000);
        send_sample(32'sh8000_0000);
    endtask

    // A gain of 1.5 on one LSB gives 1.5 LSB: positive values round down, and
    // negative ones must truncate toward zero rather than toward minus infinity.
    task automatic test_rounding();
        set_config(32'h0, 32'h0001_8000, 32'h0, 32'h0);
        send_sample(32'shFFFF_FFFF);
        send_sample(32'sh0000_0001);
        send_sample(32'shFFFF_FFFD);
        send_sample(32'sh0000_0000);
    endtask

    // Zero gain forces z to zero whatever the sample; a full-scale drift then
    // drives both sums to the zero clamp.
    task automatic test_zero_gain_and_drift();
        set_config(32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        set_config(32'h0, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000);
        send_sample(32'sh0003_0000);
        send_sample(32'shFFFD_0000);
    endtask

    // Writes to indexes past the last register must leave the settings alone.
    task automatic test_unused_index();
        wait_idle();
        write_reg(CFG_UNUSED_FIRST, '1);
        write_reg(CFG_UNUSED_MID, '1);
        write_reg(CFG_UNUSED_TOP, '1);
        send_sample(32'sh0002_0000);
        send_sample(32'shFFFE_0000);
        send_sample(32'sh0000_0000);
    endtask

    // Random traffic in six settings of 250 samples. Most samples come in runs
    // around a level relative to the mean, so that the sums climb and decay and
    // the alarms toggle as they would on real level shifts; the rest is
    // full-range noise and extreme codes. The idle rates change every two
    // settings, and the fourth setting draws every register from the full range.
    task automatic test_random_traffic();
        int     seg;
        int     k;
        int     pick;
        int     run_left;
        int     level;
        int     mean;
        longint val;
        for (seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                send_idle_pct  = 85;
                recv_stall_pct = 25;
            end else if (seg == 4) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (seg == 3) begin
                set_config($urandom(), $urandom(), $urandom(), $urandom());
            end else begin
                mean = int'($urandom_range(32'h6_0000)) - 32'sh3_0000;
                set_config(mean, $urandom_range(32'h4000, 32'h4_0000),
                           $urandom_range(32'h1_8000), $urandom_range(32'h1_0000, 32'hA_0000));
            end
            run_left = 0;
            for (k = 0; k < 250; k++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(10, 50);
                    case ($urandom_range(3))
                        0:       level = 0;
                        1:       level = int'($urandom_range(32'h8_0000));
                        2:       level = -int'($urandom_range(32'h8_0000));
                        default: level = int'($urandom());
                    endcase
                end
                run_left--;
                pick = $urandom_range(99);
                if (pick < 85) begin
                    val = longint'(level) + longint'(model_mean)
                        + longint'($urandom_range(32'h4_0000)) - 64'sh2_0000;
                end else if (pick < 95) begin
                    val = longint'($urandom());
                end else begin
                    case ($urandom_range(3))
                        0:       val = 64'sh7FFF_FFFF;
                        1:       val = -64'sh8000_0000;
                        2:       val = 64'sh0;
                        default: val = -64'sh1;
                    endcase
                end
                send_sample(tscd_pkg::SAMPLE_W'(val));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_saturation();
        test_rounding();
        test_zero_gain_and_drift();
        test_unused_index();
        test_random_traffic();

        // Drain the pipeline; a result that never shows up trips the cycle limit.
        wait_idle();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
